// ----- src/hmrr_pkg.sv -----
// ---------------------------------------------------------------------------
// hmrr_pkg
// Types and constants shared by the histogram matching block and its RAM.
// ---------------------------------------------------------------------------
package hmrr_pkg;

    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 8;
    localparam int TVALUE_W   = 33;
    localparam int PIXEL_W    = 8;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int ROI_W      = 13;
    localparam int BINS_CFG_W = 9;
    localparam int INC_W      = 25;
    localparam int REF_W      = 33;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_INC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_REF = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_X_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_Y_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_X_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_Y_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_BINS    = 3'd4;

    localparam logic [ROI_W-1:0]      ROI_MAX_RESET  = 13'd4096;
    localparam logic [BINS_CFG_W-1:0] BINS_RESET     = 9'd256;
    localparam logic [PIXEL_W-1:0]    PIXEL_FULL     = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- src/hmrr_ram.sv -----
// ---------------------------------------------------------------------------
// hmrr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module hmrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/histogram_match_remap_roi_top.sv -----
// ---------------------------------------------------------------------------
// histogram_match_remap_roi_top
// Histogram specification of pixels inside a rectangular region, with the
// incoming cumulative counts and the reference cumulative histogram held in
// two RAMs that load items fill.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | to block  | in_valid / in_ready  | kind, table_index, table_value,
//          |           |                      | pixel_value, pixel_x, pixel_y
//  out     | from block| out_valid / out_ready| out_value, above_reference,
//          |           |                      | in_region
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Load items are written from the idle state. A pixel outside the region goes
//  straight to the result; one inside searches up to n bins (n = bins searched,
//  256 at reset): the reference read port gives one bin per cycle during search.
//  Reset is asynchronous and clears control and configuration; the tables
//  are undefined until loaded. A finished result waits in the output
//  register while the next item is taken; a stalled output holds the block
//  only once the following result is ready.
// ---------------------------------------------------------------------------
module histogram_match_remap_roi_top #(
    parameter int BINS      = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hmrr_pkg::KIND_W-1:0]       kind,
    input  logic [hmrr_pkg::INDEX_W-1:0]      table_index,
    input  logic [hmrr_pkg::TVALUE_W-1:0]     table_value,
    input  logic [hmrr_pkg::PIXEL_W-1:0]      pixel_value,
    input  logic [hmrr_pkg::COORD_W-1:0]      pixel_x,
    input  logic [hmrr_pkg::COORD_W-1:0]      pixel_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hmrr_pkg::PIXEL_W-1:0]      out_value,
    output logic                              above_reference,
    output logic                              in_region,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hmrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hmrr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import hmrr_pkg::*;

    localparam int AW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int SW   = INC_W + FRAC_BITS;
    localparam int CMPW = (SW > REF_W) ? SW : REF_W;
    localparam logic [CMPW-1:0] HALF = CMPW'(1) << (FRAC_BITS - 1);

    // configuration
    logic [ROI_W-1:0]      x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic [BINS_CFG_W-1:0] bins_used_reg;

    // control and datapath
    state_t              state_reg, state_next;
    logic [AW-1:0]       last_reg;
    logic [AW-1:0]       scan_idx_reg;
    logic [CMPW-1:0]     thr_reg;
    logic [PIXEL_W-1:0]  res_value_reg;
    logic                res_above_reg;
    logic                res_region_reg;
    logic                out_valid_reg;
    logic [PIXEL_W-1:0]  out_value_reg;
    logic                out_above_reg;
    logic                out_region_reg;

    // RAM ports
    logic                inc_we, ref_we, inc_re, ref_re;
    logic [AW-1:0]       waddr, inc_raddr, ref_raddr;
    logic [INC_W-1:0]    inc_rdata;
    logic [REF_W-1:0]    ref_rdata;

    // combinational helpers
    logic                accept_pixel;
    logic                in_roi;
    logic                index_ok;
    logic [AW-1:0]       pixel_addr;
    logic [AW-1:0]       last_comb;
    logic [CMPW-1:0]     scaled;
    logic [CMPW-1:0]     ref_ext;
    logic                above;
    logic [CMPW-1:0]     thr_comb;
    logic                hit;
    logic                scan_last;
    logic                out_load;
    logic [PIXEL_W-1:0]  idx_clip;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg     <= '0;
            y_min_reg     <= '0;
            x_max_reg     <= ROI_MAX_RESET;
            y_max_reg     <= ROI_MAX_RESET;
            bins_used_reg <= BINS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROI_X_MIN: x_min_reg     <= cfg_data;
                CFG_ROI_Y_MIN: y_min_reg     <= cfg_data;
                CFG_ROI_X_MAX: x_max_reg     <= cfg_data;
                CFG_ROI_Y_MAX: y_max_reg     <= cfg_data;
                CFG_REF_BINS:  bins_used_reg <= cfg_data[BINS_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    assign accept_pixel = in_valid && in_ready && (kind == KIND_PIXEL);
    assign in_roi = ({1'b0, pixel_x} >= x_min_reg) && ({1'b0, pixel_x} < x_max_reg) &&
                    ({1'b0, pixel_y} >= y_min_reg) && ({1'b0, pixel_y} < y_max_reg);
    assign index_ok   = 32'(table_index) < BINS;
    assign pixel_addr = (32'(pixel_value) < BINS) ? AW'(pixel_value) : AW'(BINS - 1);

    // saturate the searched bin count into [1, BINS], keep the last bin
    always_comb
    begin
        if (bins_used_reg == '0)
        begin
            last_comb = '0;
        end
        else if (32'(bins_used_reg) > BINS)
        begin
            last_comb = AW'(BINS - 1);
        end
        else
        begin
            last_comb = AW'(bins_used_reg - BINS_CFG_W'(1));
        end
    end

    assign scaled   = CMPW'(inc_rdata) << FRAC_BITS;
    assign ref_ext  = CMPW'(ref_rdata);
    assign above    = scaled > ref_ext;
    assign thr_comb = (scaled >= HALF) ? (scaled - HALF) : '0;
    assign hit       = ref_ext >= thr_reg;
    assign scan_last = scan_idx_reg == last_reg;
    assign idx_clip  = (32'(scan_idx_reg) > 255) ? PIXEL_FULL : PIXEL_W'(scan_idx_reg);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_pixel)
                begin
                    state_next = in_roi ? ST_LOOK : ST_DONE;
                end
            end
            ST_LOOK:
            begin
                state_next = above ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit || scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine: handshake and RAM ports
    always_comb
    begin
        in_ready  = 1'b0;
        inc_we    = 1'b0;
        ref_we    = 1'b0;
        inc_re    = 1'b0;
        ref_re    = 1'b0;
        waddr     = AW'(table_index);
        inc_raddr = pixel_addr;
        ref_raddr = last_comb;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                inc_we   = in_valid && (kind == KIND_LOAD_INC) && index_ok;
                ref_we   = in_valid && (kind == KIND_LOAD_REF) && index_ok;
                inc_re   = accept_pixel && in_roi;
                ref_re   = accept_pixel && in_roi;
            end
            ST_LOOK:
            begin
                ref_re    = !above;
                ref_raddr = '0;
            end
            ST_SCAN:
            begin
                ref_re    = !hit && !scan_last;
                ref_raddr = scan_idx_reg + AW'(1);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    hmrr_ram #(
        .WIDTH (INC_W),
        .DEPTH (BINS)
    ) u_inc_ram (
        .clk   (clk),
        .we    (inc_we),
        .waddr (waddr),
        .wdata (table_value[INC_W-1:0]),
        .re    (inc_re),
        .raddr (inc_raddr),
        .rdata (inc_rdata)
    );

    hmrr_ram #(
        .WIDTH (REF_W),
        .DEPTH (BINS)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (waddr),
        .wdata (table_value[REF_W-1:0]),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_pixel)
                begin
                    last_reg       <= last_comb;
                    res_value_reg  <= pixel_value;
                    res_above_reg  <= 1'b0;
                    res_region_reg <= in_roi;
                end
            end
            ST_LOOK:
            begin
                if (above)
                begin
                    res_value_reg <= PIXEL_FULL;
                    res_above_reg <= 1'b1;
                end
                thr_reg      <= thr_comb;
                scan_idx_reg <= '0;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_value_reg <= idx_clip;
                end
                else if (scan_last)
                begin
                    res_value_reg <= PIXEL_FULL;
                end
                else
                begin
                    // advance to the bin whose read is now in flight
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_value_reg  <= res_value_reg;
                    out_above_reg  <= res_above_reg;
                    out_region_reg <= res_region_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign out_value       = out_value_reg;
    assign above_reference = out_above_reg;
    assign in_region       = out_region_reg;

    // the search never runs past the last searched bin
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_idx_reg <= last_reg)
        else $error("reference search past last bin");

    // tables are not written while a pixel is in work
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !inc_we && !ref_we)
        else $error("table write during pixel work");

    // a forced result only comes from a remapped pixel and reads full scale
    a_above_forced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && above_reference |-> in_region && out_value == PIXEL_FULL)
        else $error("above_reference without forced full-scale remap");

    // a pixel transfer always leads into the lookup or the result stage
    a_pixel_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept_pixel |=> state_reg == ST_LOOK || state_reg == ST_DONE)
        else $error("pixel transfer left the block idle");

endmodule

// ----- tb/sv/tb_histogram_match_remap_roi_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_histogram_match_remap_roi_top
// Self-checking bench for the region-limited histogram matching block. The
// bench keeps its own copy of both cumulative tables and of the region and
// bin-count registers, predicts one remap result per pixel transfer and
// compares every output transfer against the oldest prediction. Directed
// cases cover field extremes, rounding at the half-count boundary, bin count
// saturation, region edges, empty and inverted regions, spare item kinds and
// unknown register indexes; random traffic follows over several settings.
// ---------------------------------------------------------------------------
module tb_histogram_match_remap_roi_top;
    import hmrr_pkg::*;

    localparam int BINS         = 256;
    localparam int FRAC_BITS    = 8;
    localparam int HALF_STEP    = 1 << (FRAC_BITS - 1);
    localparam int DRAIN_CYCLES = 300;
    localparam int CNT_SPAN     = 4000;
    localparam int INC_TOP      = (1 << INC_W) - 1;

    localparam logic [KIND_W-1:0]    KIND_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_REF_BINS + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_REF_BINS + 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = CFG_REF_BINS + 3'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic               above;
        logic               region;
    } remap_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind;
    logic [INDEX_W-1:0]     table_index;
    logic [TVALUE_W-1:0]    table_value;
    logic [PIXEL_W-1:0]     pixel_value;
    logic [COORD_W-1:0]     pixel_x;
    logic [COORD_W-1:0]     pixel_y;
    logic                   out_valid;
    logic                   out_ready;
    logic [PIXEL_W-1:0]     out_value;
    logic                   above_reference;
    logic                   in_region;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow state of the block
    logic [INC_W-1:0]       inc_counts [BINS];
    logic [REF_W-1:0]       ref_cdf [BINS];
    logic [ROI_W-1:0]       x_lo, y_lo, x_hi, y_hi;
    logic [BINS_CFG_W-1:0]  bins_reg;

    remap_t                 pending_remaps [$];
    int                     recent_bins [$];
    bit                     gaps_on;
    int                     mismatches;
    int                     pixels_sent, loads_sent, reg_writes;
    int                     inside_seen, above_seen;
    logic [REF_W-1:0]       fill_top;

    histogram_match_remap_roi_top #(
        .BINS      (BINS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .table_index     (table_index),
        .table_value     (table_value),
        .pixel_value     (pixel_value),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_value       (out_value),
        .above_reference (above_reference),
        .in_region       (in_region),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("histogram_match_remap_roi_top verification failed");
        $finish;
    end

    function automatic int draw_gap();
        return gaps_on ? $urandom_range(0, 11) : 0;
    endfunction

    function automatic int bins_in_use();
        int n;
        n = bins_reg;
        if (n < 1)
            n = 1;
        if (n > BINS)
            n = BINS;
        return n;
    endfunction

    function automatic logic [TVALUE_W-1:0] rand_word33();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TVALUE_W-1:0];
    endfunction

    // count in the low bits, junk above them that the block must drop
    function automatic logic [TVALUE_W-1:0] incoming_word(logic [INC_W-1:0] count);
        logic [TVALUE_W-1:0] w;
        w = rand_word33();
        w[INC_W-1:0] = count;
        return w;
    endfunction

    function automatic remap_t remap_pixel(logic [PIXEL_W-1:0] pix, logic [COORD_W-1:0] x,
                                           logic [COORD_W-1:0] y);
        remap_t          r;
        longint unsigned scaled, thr;
        int              n, i;
        bit              found;
        r.region = (x >= x_lo) && (x < x_hi) && (y >= y_lo) && (y < y_hi);
        r.above  = 1'b0;
        r.value  = pix;
        if (!r.region)
            return r;
        n = bins_in_use();
        scaled = longint'(inc_counts[pix]) << FRAC_BITS;
        if (scaled > ref_cdf[n-1])
        begin
            r.value = PIXEL_FULL;
            r.above = 1'b1;
            return r;
        end
        thr = (scaled >= HALF_STEP) ? scaled - HALF_STEP : 0;
        r.value = PIXEL_FULL;
        found = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!found && ref_cdf[i] >= thr)
            begin
                r.value = i[PIXEL_W-1:0];
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int lo, int hi);
        int sel, c;
        sel = $urandom_range(0, 9);
        c = $urandom_range(0, 4095);
        if (sel < 5 && lo < hi && lo <= 4095)
            c = $urandom_range(lo, (hi > 4096) ? 4095 : hi - 1);
        else if (sel < 7)
        begin
            case ($urandom_range(0, 3))
                0: c = lo;
                1: c = hi - 1;
                2: c = hi;
                default: c = lo - 1;
            endcase
            if (c < 0 || c > 4095)
                c = $urandom_range(0, 4095);
        end
        return c[COORD_W-1:0];
    endfunction

    task automatic send_item(logic [KIND_W-1:0] item_kind, logic [INDEX_W-1:0] idx,
                             logic [TVALUE_W-1:0] word, logic [PIXEL_W-1:0] pix,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= item_kind;
        table_index <= idx;
        table_value <= word;
        pixel_value <= pix;
        pixel_x     <= x;
        pixel_y     <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (item_kind)
            KIND_LOAD_INC:
            begin
                inc_counts[idx] = word[INC_W-1:0];
                loads_sent++;
            end
            KIND_LOAD_REF:
            begin
                ref_cdf[idx] = word;
                loads_sent++;
            end
            KIND_PIXEL:
            begin
                pending_remaps.push_back(remap_pixel(pix, x, y));
                pixels_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic send_load(logic [KIND_W-1:0] item_kind, int idx, logic [TVALUE_W-1:0] word);
        send_item(item_kind, idx[INDEX_W-1:0], word, $urandom_range(0, 255),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    task automatic send_pixel(int pix, int x, int y);
        send_item(KIND_PIXEL, $urandom_range(0, 255), rand_word33(), pix[PIXEL_W-1:0],
                  x[COORD_W-1:0], y[COORD_W-1:0]);
    endtask

    // drop valid and wait for every outstanding result
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_remaps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROI_X_MIN: x_lo = data;
            CFG_ROI_Y_MIN: y_lo = data;
            CFG_ROI_X_MAX: x_hi = data;
            CFG_ROI_Y_MAX: y_hi = data;
            CFG_REF_BINS:  bins_reg = data[BINS_CFG_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // registers change only once the block has gone quiet
    task automatic set_config(int x_first, int y_first, int x_end, int y_end, int bins_word);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_ROI_X_MIN, x_first[CFG_DATA_W-1:0]);
        write_reg(CFG_ROI_Y_MIN, y_first[CFG_DATA_W-1:0]);
        write_reg(CFG_ROI_X_MAX, x_end[CFG_DATA_W-1:0]);
        write_reg(CFG_ROI_Y_MAX, y_end[CFG_DATA_W-1:0]);
        write_reg(CFG_REF_BINS, bins_word[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // output side: random stalls, one check per transfer
    initial
    begin
        int     gap;
        remap_t want;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_remaps.size() == 0)
            begin
                $error("unexpected result: out_value=%0d above_reference=%0d in_region=%0d",
                       out_value, above_reference, in_region);
                mismatches++;
            end
            else
            begin
                want = pending_remaps.pop_front();
                if (want.region)
                    inside_seen++;
                if (want.above)
                    above_seen++;
                if (out_value !== want.value)
                begin
                    $error("out_value: expected %0d, actual %0d", want.value, out_value);
                    mismatches++;
                end
                if (above_reference !== want.above)
                begin
                    $error("above_reference: expected %0d, actual %0d", want.above,
                           above_reference);
                    mismatches++;
                end
                if (in_region !== want.region)
                begin
                    $error("in_region: expected %0d, actual %0d", want.region, in_region);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_table_fill();
        longint unsigned acc_ref;
        int              acc_inc, i;
        acc_ref = 0;
        acc_inc = 0;
        for (i = 0; i < BINS; i++)
        begin
            acc_ref += $urandom_range(0, 2 * CNT_SPAN);
            acc_inc += $urandom_range(0, 2 * CNT_SPAN / BINS);
            send_load(KIND_LOAD_REF, i, acc_ref[TVALUE_W-1:0]);
            send_load(KIND_LOAD_INC, i, incoming_word(acc_inc[INC_W-1:0]));
        end
        fill_top = acc_ref[REF_W-1:0];
    endtask

    task automatic test_reset_region();
        send_pixel(0, 0, 0);
        send_pixel(255, 4095, 4095);
        send_pixel(17, 4095, 0);
    endtask

    task automatic test_extreme_values();
        send_load(KIND_LOAD_REF, 0, '0);
        send_load(KIND_LOAD_REF, BINS - 1, {TVALUE_W{1'b1}});
        send_load(KIND_LOAD_INC, 7, {TVALUE_W{1'b1}});
        send_load(KIND_LOAD_INC, 4, incoming_word('0));
        send_pixel(7, 0, 0);
        send_pixel(4, 4095, 4095);
    endtask

    // reference value exactly half a count below the scaled count
    task automatic test_rounding_boundary();
        longint unsigned c;
        c = (ref_cdf[99] >> FRAC_BITS) + 2;
        send_load(KIND_LOAD_REF, 99, (c << FRAC_BITS) - HALF_STEP - 1);
        send_load(KIND_LOAD_REF, 100, (c << FRAC_BITS) - HALF_STEP);
        send_load(KIND_LOAD_INC, 3, incoming_word(c[INC_W-1:0]));
        send_pixel(3, 100, 200);
    endtask

    task automatic test_bin_count_limits();
        // zero saturates to one bin, the largest word to all bins
        set_config(0, 0, ROI_MAX_RESET, ROI_MAX_RESET, 13'h1E00);
        send_pixel(7, 10, 10);
        send_pixel(4, 11, 10);
        set_config(0, 0, ROI_MAX_RESET, ROI_MAX_RESET, 13'h1FFF);
        send_pixel(7, 12, 10);
        send_load(KIND_LOAD_REF, BINS - 1, fill_top);
        send_pixel(7, 13, 10);
    endtask

    task automatic test_unknown_register();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_SPARE_A, 13'h1FFF);
        write_reg(CFG_SPARE_B, 13'h0000);
        write_reg(CFG_SPARE_C, 13'h0AAA);
        cfg_valid <= 1'b0;
        send_pixel(3, 50, 50);
    endtask

    task automatic test_spare_kind();
        send_item(KIND_SPARE, 8'hFF, rand_word33(), 8'hFF, 12'hFFF, 12'hFFF);
        send_item(KIND_SPARE, 8'h00, '0, 8'h00, 12'h000, 12'h000);
        send_pixel(3, 60, 60);
    endtask

    task automatic test_region_edges();
        set_config(100, 50, 200, 60, BINS_RESET);
        send_pixel(10, 99, 55);
        send_pixel(10, 100, 55);
        send_pixel(10, 199, 59);
        send_pixel(10, 200, 55);
        send_pixel(10, 150, 60);
        set_config(300, 300, 300, 300, 8);
        send_pixel(20, 300, 300);
        set_config(4095, 10, 4000, 20, 8);
        send_pixel(30, 4095, 15);
        set_config(4095, 4095, ROI_MAX_RESET, ROI_MAX_RESET, 8);
        send_pixel(40, 4095, 4095);
        send_pixel(40, 4094, 4095);
    endtask

    task automatic test_random_traffic();
        int              phase_items [4] = '{70, 90, 80, 70};
        int              ph, it, sel, idx, n, pix, x_first, y_first, x_end, y_end, bins_word;
        longint unsigned lim, lo, hi, span, word;
        for (ph = 0; ph < 4; ph++)
        begin
            x_first = $urandom_range(0, 3900);
            y_first = $urandom_range(0, 3900);
            x_end   = x_first + $urandom_range(1, 4096 - x_first);
            y_end   = y_first + $urandom_range(1, 4096 - y_first);
            case (ph)
                0: bins_word = BINS_RESET;
                1:
                begin
                    bins_word = $urandom_range(1, 32);
                    x_first = 0;
                    y_first = 0;
                    x_end = ROI_MAX_RESET;
                    y_end = ROI_MAX_RESET;
                end
                2: bins_word = $urandom_range(2, 64);
                default: bins_word = $urandom_range(1, 16) | ($urandom_range(0, 15) << 9);
            endcase
            set_config(x_first, y_first, x_end, y_end, bins_word);
            recent_bins.delete();
            for (it = 0; it < phase_items[ph]; it++)
            begin
                if (it % 32 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                if (ph == 1 && it == phase_items[ph] / 2)
                    hold_until_drained();
                sel = $urandom_range(0, 99);
                if (sel < 22)
                begin
                    // counts scaled to the bins now searched
                    n = bins_in_use();
                    lim = ref_cdf[n-1] >> FRAC_BITS;
                    lim = lim + lim / 8 + 2;
                    if (lim > INC_TOP)
                        lim = INC_TOP;
                    idx = $urandom_range(0, BINS - 1);
                    send_load(KIND_LOAD_INC, idx, incoming_word($urandom_range(0, lim)));
                    recent_bins.push_back(idx);
                    if (recent_bins.size() > 32)
                        void'(recent_bins.pop_front());
                end
                else if (sel < 30)
                begin
                    idx = $urandom_range(0, BINS - 1);
                    lo = (idx > 0) ? ref_cdf[idx-1] : 0;
                    hi = (idx < BINS - 1) ? ref_cdf[idx+1] : lo + 2 * CNT_SPAN;
                    if (hi < lo)
                    begin
                        span = hi;
                        hi = lo;
                        lo = span;
                    end
                    span = hi - lo;
                    if (span > 64'hFFFF_FFFF)
                        span = 64'hFFFF_FFFF;
                    word = lo + $urandom_range(0, span);
                    if ($urandom_range(0, 5) == 0)
                        word = $urandom_range(0, CNT_SPAN * 512);
                    send_load(KIND_LOAD_REF, idx, word[TVALUE_W-1:0]);
                end
                else if (sel < 33)
                    send_item(KIND_SPARE, $urandom_range(0, 255), rand_word33(),
                              $urandom_range(0, 255), $urandom_range(0, 4095),
                              $urandom_range(0, 4095));
                else
                begin
                    pix = $urandom_range(0, 255);
                    if (recent_bins.size() != 0 && $urandom_range(0, 1) == 1)
                        pix = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
                    send_pixel(pix, pick_coord(x_lo, x_hi), pick_coord(y_lo, y_hi));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_PIXEL;
        table_index <= '0;
        table_value <= '0;
        pixel_value <= '0;
        pixel_x     <= '0;
        pixel_y     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_ROI_X_MIN;
        cfg_data    <= '0;
        x_lo        = '0;
        y_lo        = '0;
        x_hi        = ROI_MAX_RESET;
        y_hi        = ROI_MAX_RESET;
        bins_reg    = BINS_RESET;
        gaps_on     = 1'b1;
        mismatches  = 0;
        pixels_sent = 0;
        loads_sent  = 0;
        reg_writes  = 0;
        inside_seen = 0;
        above_seen  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_reset_region();
        test_extreme_values();
        test_rounding_boundary();
        test_bin_count_limits();
        test_unknown_register();
        test_spare_kind();
        test_region_edges();
        test_random_traffic();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d pixels and %0d table loads over %0d register writes.",
                 pixels_sent, loads_sent, reg_writes);
        $display("Checked %0d remapped pixels, %0d of them forced above the reference.",
                 inside_seen, above_seen);
        if (mismatches == 0)
            $display("histogram_match_remap_roi_top verification clean");
        else
            $display("histogram_match_remap_roi_top verification failed");
        $finish;
    end

endmodule
